[rtl/core/fct_pkg.sv]
// shared types and constants for the frequency count tracker
// no dependencies; used by fct_ctrl, fct_dp and frequency_count_tracker_core
package fct_pkg;

	localparam int NUM_KEYS  = 4096;
	localparam int KEY_W     = 12;
	localparam int CNT_W     = 10;
	localparam int BKT_W     = 13;
	localparam int NUM_BKTS  = 1024;

	localparam logic [CNT_W-1:0] MAX_COUNT = 10'd1023;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] query_frequency;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] key_count;
		logic             saturated;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic clr;
		logic accept;
		logic eval;
		logic brd_old;
		logic brd_new;
		logic bwr_old;
		logic bwr_new;
		logic done;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic no_update;
		logic old_nz;
		logic new_nz;
	} stat_t;

endpackage

[rtl/core/fct_ctrl.sv]
// sequencer for the frequency count tracker: clear sweep, lookup, bucket moves
// depends on fct_pkg
module fct_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  fct_pkg::stat_t st,
	output fct_pkg::cmd_t  cmd,
	output logic           busy
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_BOLD  = 3'd3;
	localparam logic [2:0] S_BNEW  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (st.no_update) begin
					cmd.done = 1'b1;
					state_d  = S_IDLE;
				end else if (st.old_nz) begin
					cmd.brd_old = 1'b1;
					state_d     = S_BOLD;
				end else begin
					cmd.brd_new = 1'b1;
					state_d     = S_BNEW;
				end
			end
			S_BOLD: begin
				cmd.bwr_old = 1'b1;
				if (st.new_nz) begin
					cmd.brd_new = 1'b1;
					state_d     = S_BNEW;
				end else begin
					cmd.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_BNEW: begin
				cmd.bwr_new = 1'b1;
				cmd.done    = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/fct_dp.sv]
// datapath: per-key count memory, keys-per-frequency memory, result register
// depends on fct_pkg
module fct_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  fct_pkg::cmd_t  cmd,
	input  fct_pkg::req_t  req,
	output fct_pkg::stat_t st,
	output logic           done,
	output fct_pkg::rsp_t  rsp
);

	logic [fct_pkg::CNT_W-1:0] kmem [fct_pkg::NUM_KEYS];
	logic [fct_pkg::BKT_W-1:0] bmem [fct_pkg::NUM_BKTS];

	fct_pkg::req_t             req_q;
	fct_pkg::rsp_t             rsp_q;
	logic                      done_q;
	logic [fct_pkg::KEY_W-1:0] clr_cnt_q;
	logic [fct_pkg::CNT_W-1:0] kmem_rd_q;
	logic [fct_pkg::BKT_W-1:0] bmem_rd_q;
	logic [fct_pkg::CNT_W-1:0] cnt_old_q;
	logic [fct_pkg::CNT_W-1:0] cnt_new_q;

	logic                      is_add;
	logic                      is_del;
	logic                      upd;
	logic [fct_pkg::CNT_W-1:0] c_next;
	logic [fct_pkg::CNT_W-1:0] brd_addr;
	logic                      brd_en;

	assign is_add = (req_q.opcode == fct_pkg::OP_ADD);
	assign is_del = (req_q.opcode == fct_pkg::OP_DELETE);
	assign upd    = (is_add && (kmem_rd_q != fct_pkg::MAX_COUNT)) ||
	                (is_del && (kmem_rd_q != '0));
	assign c_next = is_add ? kmem_rd_q + fct_pkg::CNT_W'(1) : kmem_rd_q - fct_pkg::CNT_W'(1);

	assign st.clr_last  = (clr_cnt_q == fct_pkg::KEY_W'(fct_pkg::NUM_KEYS - 1));
	assign st.no_update = !upd;
	assign st.old_nz    = (kmem_rd_q != '0);
	assign st.new_nz    = (cnt_new_q != '0);

	// one bucket read per cycle: query bucket, old bucket or new bucket
	always_comb begin
		brd_en   = cmd.accept | cmd.brd_old | cmd.brd_new;
		brd_addr = cnt_new_q;
		if (cmd.accept) begin
			brd_addr = req.query_frequency;
		end else if (cmd.brd_old) begin
			brd_addr = kmem_rd_q;
		end else if (cmd.eval) begin
			brd_addr = c_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			kmem[clr_cnt_q] <= '0;
		end else if (cmd.eval && upd) begin
			kmem[req_q.key] <= c_next;
		end
		if (cmd.accept) begin
			kmem_rd_q <= kmem[req.key];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			bmem[clr_cnt_q[fct_pkg::CNT_W-1:0]] <= '0;
		end else if (cmd.bwr_old) begin
			if (bmem_rd_q != '0) begin
				bmem[cnt_old_q] <= bmem_rd_q - fct_pkg::BKT_W'(1);
			end
		end else if (cmd.bwr_new) begin
			bmem[cnt_new_q] <= bmem_rd_q + fct_pkg::BKT_W'(1);
		end
		if (brd_en) begin
			bmem_rd_q <= bmem[brd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
		if (cmd.eval) begin
			cnt_old_q         <= kmem_rd_q;
			cnt_new_q         <= c_next;
			rsp_q.found       <= (req_q.opcode == fct_pkg::OP_QUERY) &&
			                     (req_q.query_frequency != '0) && (bmem_rd_q != '0);
			rsp_q.key_count   <= (is_add || is_del) ? (upd ? c_next : kmem_rd_q) : '0;
			rsp_q.saturated   <= is_add && (kmem_rd_q == fct_pkg::MAX_COUNT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.done;
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + fct_pkg::KEY_W'(1);
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[rtl/core/frequency_count_tracker_core.sv]
// Frequency count tracker: per-key occurrence counts plus a count-of-counts table.
// After reset the block sweeps both memories to zero, one key address per cycle,
// over all 4096 keys; busy stays high during the sweep. A request is taken when
// start is high and busy is low. Its result is on rsp while done is high for a
// single cycle, and cannot be held off. Each request is handled alone: a query, a
// saturated add, a delete of an absent key or an unused opcode ends after the
// evaluate step; an add from zero adds the new-bucket step, a delete to zero the
// old-bucket step, any other add or delete both in turn, set by the bucket memory's
// single read port: the count read feeds the bucket address.
// depends on fct_pkg, fct_ctrl, fct_dp
module frequency_count_tracker_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fct_pkg::req_t req,
	output logic          done,
	output fct_pkg::rsp_t rsp
);

	fct_pkg::cmd_t  cmd;
	fct_pkg::stat_t st;

	fct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	fct_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.st     (st),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
